/* rtl/hsmm_pkg.sv */
// ----------------------------------------------------------------------------
// hsmm_pkg
// Shared types, constants and helpers of the metering statistics block.
// ----------------------------------------------------------------------------
package hsmm_pkg;

  localparam int CHANNELS = 16;
  localparam int BINS     = 12;
  localparam int CH_W     = 4;
  localparam int BIN_W    = 4;
  localparam int DEPTH    = CHANNELS * BINS;
  localparam int ADDR_W   = $clog2(DEPTH);
  localparam int IN_W     = 48;
  localparam int OUT_W    = 168;

  typedef enum logic [1:0] {
    OP_ACC   = 2'd0,
    OP_BOUND = 2'd1,
    OP_CLEAR = 2'd2,
    OP_READ  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_REJECT = 2'd1,
    ST_EMPTY  = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_SRCH, S_SCMP, S_CRD, S_UPD, S_BWR, S_CLR, S_RSUM, S_DGO, S_DWAIT,
    S_OUT
  } state_e;

  // per-channel statistics word
  typedef struct packed {
    logic signed [63:0] total;
    logic signed [31:0] minimum;
    logic signed [31:0] maximum;
    logic        [31:0] count;
  } stats_t;

  // result item, status in the lowest bits
  typedef struct packed {
    logic signed [31:0] maximum;
    logic signed [31:0] minimum;
    logic signed [31:0] average;
    logic        [31:0] sample_count;
    logic        [31:0] bin_count;
    logic [BIN_W-1:0]   bin_hit;
    logic [1:0]         status;
  } res_t;

  typedef struct packed {
    logic start;
    logic long_mode;
  } div_req_t;

  // flooring step in milli-units for the decimal places kept
  function automatic logic [31:0] dec_step(input logic [1:0] dp);
    logic [31:0] s;
    case (dp)
      2'd3:    s = 32'd1;
      2'd2:    s = 32'd10;
      2'd1:    s = 32'd100;
      default: s = 32'd1000;
    endcase
    return s;
  endfunction

endpackage

/* rtl/hsmm_ram.sv */
// ----------------------------------------------------------------------------
// hsmm_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module hsmm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 192
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

/* rtl/hsmm_div.sv */
// ----------------------------------------------------------------------------
// hsmm_div
// Floor unit: bit-serial 64-by-32 floored quotient for the average (long
// mode), and flooring of a 32-bit value to a multiple of 1, 10, 100 or 1000
// by reciprocal multiplication (short mode). Both clamped to 32 bits signed.
// ----------------------------------------------------------------------------
module hsmm_div (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  hsmm_pkg::div_req_t    req_i,
  input  logic signed [63:0]    dividend_i,
  input  logic        [31:0]    divisor_i,
  output logic                  done_o,
  output logic signed [31:0]    quot_o,
  output logic signed [31:0]    floor_o
);

  logic        run_q, done_q, neg_q, fneg_q;
  logic [5:0]  cnt_q, fsh_q;
  logic [9:0]  fstep_q;
  logic [31:0] div_q, rem_q;
  logic [63:0] quo_q, fprod_q;
  logic [63:0] mag;
  logic [32:0] shifted;
  logic [33:0] diff;
  logic        ge;
  logic [64:0] qmag, q65;
  logic [31:0] fx, fmagic, fq;
  logic [5:0]  fsh;
  logic signed [31:0] fqs;
  logic signed [42:0] fprd;

  assign mag     = dividend_i[63] ? 64'(-dividend_i) : dividend_i;
  assign shifted = {rem_q, quo_q[63]};
  assign diff    = {1'b0, shifted} - {2'b00, div_q};
  assign ge      = ~diff[33];

  // floor(v / s) = ~floor(~v / s) for negative v, so divide a magnitude only
  assign fx = dividend_i[31] ? ~dividend_i[31:0] : dividend_i[31:0];

  always_comb begin
    unique case (divisor_i)
      32'd10: begin
        fmagic = 32'hCCCCCCCD;
        fsh    = 6'd35;
      end
      32'd100: begin
        fmagic = 32'h51EB851F;
        fsh    = 6'd37;
      end
      32'd1000: begin
        fmagic = 32'h10624DD3;
        fsh    = 6'd38;
      end
      default: begin
        fmagic = 32'd1;
        fsh    = 6'd0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        if (req_i.long_mode) begin
          run_q <= 1'b1;
          cnt_q <= 6'd63;
        end else begin
          done_q <= 1'b1;
        end
      end else if (run_q) begin
        cnt_q <= cnt_q - 6'd1;
        if (cnt_q == 6'd0) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      neg_q   <= dividend_i[63];
      div_q   <= divisor_i;
      rem_q   <= '0;
      quo_q   <= mag;
      fneg_q  <= dividend_i[31];
      fsh_q   <= fsh;
      fstep_q <= divisor_i[9:0];
      fprod_q <= 64'(fx) * 64'(fmagic);
    end else if (run_q) begin
      rem_q <= ge ? diff[31:0] : shifted[31:0];
      quo_q <= {quo_q[62:0], ge};
    end
  end

  // floor correction toward minus infinity
  assign qmag = {1'b0, quo_q} + 65'(neg_q && (rem_q != 32'd0));
  assign q65  = neg_q ? -qmag : qmag;

  assign fq   = 32'(fprod_q >> fsh_q);
  assign fqs  = fneg_q ? ~fq : fq;
  assign fprd = 43'(fqs) * $signed({33'd0, fstep_q});

  always_comb begin
    if ($signed(q65) > 65'sh7FFFFFFF) begin
      quot_o = 32'sh7FFFFFFF;
    end else if ($signed(q65) < -65'sh80000000) begin
      quot_o = 32'sh80000000;
    end else begin
      quot_o = q65[31:0];
    end
    if (fprd < -43'sh80000000) begin
      floor_o = 32'sh80000000;
    end else begin
      floor_o = fprd[31:0];
    end
  end

  assign done_o = done_q;

endmodule

/* rtl/histogram_min_max_avg_stats.sv */
// ----------------------------------------------------------------------------
// histogram_min_max_avg_stats
// Per-channel metering statistics with a bin histogram.
// ----------------------------------------------------------------------------
// Commands enter on the s_axis channel, one result per command leaves on
// m_axis. The block works on one command at a time; s_axis_tready is high
// only while it is idle, which it returns to as the result is loaded.
// A command is paced by one read per cycle from each RAM and by the divider:
//   accumulate: a bound read per bound searched, then the count and stats
//   update on a hit, or rejection after the last bound; clear: a bin sweep
//   bound write: a count read, then the write (none for a bin out of range)
//   read summary: the average with its 64 divider steps, then floors of
//   average, minimum and maximum; no division when the channel is empty
// Results sit in an output register; while the receiver stalls the block
// finishes the next command and then holds it until the register frees.
// After reset the block sweeps the bound and count RAMs and the statistics
// words to zero, one entry per cycle; s_axis_tready stays low until the
// sweep is done. decimal_places is written through cfg_we_i / cfg_wdata_i;
// the user must do so only while idle, the block itself does not enforce it.
// ----------------------------------------------------------------------------
module histogram_min_max_avg_stats (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  // op[1:0], channel[5:2], bin_select[9:6], sample_value[41:10]
  input  logic [hsmm_pkg::IN_W-1:0]  s_axis_tdata,
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  // status[1:0], bin_hit[5:2], bin_count[37:6], sample_count[69:38],
  // average[101:70], minimum[133:102], maximum[165:134]
  output logic [hsmm_pkg::OUT_W-1:0] m_axis_tdata,
  input  logic                       cfg_we_i,
  input  logic [1:0]                 cfg_wdata_i
);

  localparam int AW = hsmm_pkg::ADDR_W;
  localparam int BW = hsmm_pkg::BIN_W;

  hsmm_pkg::state_e state_q, state_d;
  hsmm_pkg::op_e    op_q, op_d;
  hsmm_pkg::res_t   res_q, res_d, out_q, out_d;
  hsmm_pkg::stats_t st_rd, st_wr;
  hsmm_pkg::div_req_t div_req;

  logic [hsmm_pkg::CH_W-1:0] ch_q, ch_d;
  logic [BW-1:0]    sel_q, sel_d, b_q, b_d;
  logic signed [31:0] val_q, val_d, avg_q, avg_d;
  logic [1:0]       ph_q, ph_d, dp_q;
  logic             out_valid_q, out_valid_d;
  logic [AW-1:0]    ini_q, ini_d;

  logic [AW-1:0]    base, bnd_raddr, cnt_raddr, cnt_waddr, bnd_waddr;
  logic [hsmm_pkg::CH_W-1:0] st_raddr, st_waddr;
  logic             bnd_we, cnt_we, st_we;
  logic [31:0]      cnt_wdata, bnd_wdata, bnd_rd, cnt_rd;
  logic             accept;
  logic [hsmm_pkg::CH_W-1:0] in_ch;
  logic [BW-1:0]    in_sel;

  logic signed [63:0] div_a;
  logic [31:0]      div_b;
  logic             div_done;
  logic signed [31:0] div_q, div_f;

  logic [31:0]      cnt_inc, stc_inc;
  logic signed [64:0] sum65;

  assign in_ch  = s_axis_tdata[5:2];
  assign in_sel = s_axis_tdata[9:6];
  assign s_axis_tready = (state_q == hsmm_pkg::S_IDLE);
  assign accept = s_axis_tvalid && s_axis_tready;

  assign base      = AW'(AW'(ch_q) * AW'(hsmm_pkg::BINS));
  assign bnd_raddr = base + AW'(b_q);
  assign cnt_raddr = base + AW'((op_q == hsmm_pkg::OP_ACC) ? b_q : sel_q);
  assign st_raddr  = (state_q == hsmm_pkg::S_IDLE) ? in_ch : ch_q;

  hsmm_ram #(.WIDTH(32), .DEPTH(hsmm_pkg::DEPTH)) u_bnd_ram (
    .clk_i   (clk_i),
    .we_i    (bnd_we),
    .waddr_i (bnd_waddr),
    .wdata_i (bnd_wdata),
    .raddr_i (bnd_raddr),
    .rdata_o (bnd_rd)
  );

  hsmm_ram #(.WIDTH(32), .DEPTH(hsmm_pkg::DEPTH)) u_cnt_ram (
    .clk_i   (clk_i),
    .we_i    (cnt_we),
    .waddr_i (cnt_waddr),
    .wdata_i (cnt_wdata),
    .raddr_i (cnt_raddr),
    .rdata_o (cnt_rd)
  );

  hsmm_ram #(.WIDTH($bits(hsmm_pkg::stats_t)), .DEPTH(hsmm_pkg::CHANNELS)) u_st_ram (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (st_waddr),
    .wdata_i (st_wr),
    .raddr_i (st_raddr),
    .rdata_o (st_rd)
  );

  hsmm_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (div_req),
    .dividend_i (div_a),
    .divisor_i  (div_b),
    .done_o     (div_done),
    .quot_o     (div_q),
    .floor_o    (div_f)
  );

  always_comb begin
    case (ph_q)
      2'd0: begin
        div_a = st_rd.total;
        div_b = st_rd.count;
      end
      2'd1: begin
        div_a = 64'(avg_q);
        div_b = hsmm_pkg::dec_step(dp_q);
      end
      2'd2: begin
        div_a = 64'(st_rd.minimum);
        div_b = hsmm_pkg::dec_step(dp_q);
      end
      default: begin
        div_a = 64'(st_rd.maximum);
        div_b = hsmm_pkg::dec_step(dp_q);
      end
    endcase
  end

  assign cnt_inc = (cnt_rd == '1) ? cnt_rd : cnt_rd + 32'd1;
  assign stc_inc = (st_rd.count == '1) ? st_rd.count : st_rd.count + 32'd1;
  assign sum65   = {st_rd.total[63], st_rd.total} + 65'(val_q);

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    ch_d        = ch_q;
    sel_d       = sel_q;
    val_d       = val_q;
    b_d         = b_q;
    ph_d        = ph_q;
    avg_d       = avg_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    ini_d       = ini_q;
    bnd_we      = 1'b0;
    bnd_waddr   = base + AW'(sel_q);
    bnd_wdata   = val_q;
    cnt_we      = 1'b0;
    cnt_waddr   = base + AW'(b_q);
    cnt_wdata   = '0;
    st_we       = 1'b0;
    st_waddr    = ch_q;
    st_wr       = '0;
    div_req     = '0;

    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      hsmm_pkg::S_INIT: begin
        // zero one entry of every store per cycle, the stats store only up to CHANNELS
        bnd_we    = 1'b1;
        bnd_waddr = ini_q;
        bnd_wdata = '0;
        cnt_we    = 1'b1;
        cnt_waddr = ini_q;
        st_we     = (32'(ini_q) < hsmm_pkg::CHANNELS);
        st_waddr  = ini_q[hsmm_pkg::CH_W-1:0];
        ini_d     = ini_q + AW'(1);
        if (ini_q == AW'(hsmm_pkg::DEPTH - 1)) begin
          state_d = hsmm_pkg::S_IDLE;
        end
      end
      hsmm_pkg::S_IDLE: begin
        if (accept) begin
          op_d  = hsmm_pkg::op_e'(s_axis_tdata[1:0]);
          ch_d  = in_ch;
          sel_d = in_sel;
          val_d = s_axis_tdata[41:10];
          b_d   = '0;
          res_d = '0;
          unique case (hsmm_pkg::op_e'(s_axis_tdata[1:0]))
            hsmm_pkg::OP_ACC:   state_d = hsmm_pkg::S_SRCH;
            hsmm_pkg::OP_BOUND: state_d = (32'(in_sel) < hsmm_pkg::BINS) ?
                                          hsmm_pkg::S_CRD : hsmm_pkg::S_OUT;
            hsmm_pkg::OP_CLEAR: state_d = hsmm_pkg::S_CLR;
            default:            state_d = hsmm_pkg::S_CRD;
          endcase
        end
      end
      hsmm_pkg::S_SRCH: state_d = hsmm_pkg::S_SCMP;
      hsmm_pkg::S_SCMP: begin
        if (val_q < $signed(bnd_rd)) begin
          state_d = hsmm_pkg::S_CRD;
        end else if (32'(b_q) == hsmm_pkg::BINS - 1) begin
          res_d.status       = hsmm_pkg::ST_REJECT;
          res_d.sample_count = st_rd.count;
          state_d            = hsmm_pkg::S_OUT;
        end else begin
          b_d     = b_q + BW'(1);
          state_d = hsmm_pkg::S_SRCH;
        end
      end
      hsmm_pkg::S_CRD: begin
        unique case (op_q)
          hsmm_pkg::OP_ACC:   state_d = hsmm_pkg::S_UPD;
          hsmm_pkg::OP_BOUND: state_d = hsmm_pkg::S_BWR;
          default:            state_d = hsmm_pkg::S_RSUM;
        endcase
      end
      hsmm_pkg::S_UPD: begin
        cnt_we    = 1'b1;
        cnt_wdata = cnt_inc;
        st_we     = 1'b1;
        if (sum65[64] != sum65[63]) begin
          st_wr.total = sum65[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        end else begin
          st_wr.total = sum65[63:0];
        end
        st_wr.minimum = (st_rd.count == '0 || val_q < st_rd.minimum) ? val_q : st_rd.minimum;
        st_wr.maximum = (st_rd.count == '0 || val_q > st_rd.maximum) ? val_q : st_rd.maximum;
        st_wr.count   = stc_inc;
        res_d.bin_hit      = b_q;
        res_d.bin_count    = cnt_inc;
        res_d.sample_count = stc_inc;
        state_d            = hsmm_pkg::S_OUT;
      end
      hsmm_pkg::S_BWR: begin
        bnd_we             = 1'b1;
        res_d.bin_hit      = sel_q;
        res_d.bin_count    = cnt_rd;
        res_d.sample_count = st_rd.count;
        state_d            = hsmm_pkg::S_OUT;
      end
      hsmm_pkg::S_CLR: begin
        // sweep the channel's counts, stats word on the last one
        cnt_we = 1'b1;
        b_d    = b_q + BW'(1);
        if (32'(b_q) == hsmm_pkg::BINS - 1) begin
          st_we   = 1'b1;
          state_d = hsmm_pkg::S_OUT;
        end
      end
      hsmm_pkg::S_RSUM: begin
        res_d.bin_hit      = sel_q;
        res_d.bin_count    = (32'(sel_q) < hsmm_pkg::BINS) ? cnt_rd : 32'd0;
        res_d.sample_count = st_rd.count;
        ph_d               = 2'd0;
        if (st_rd.count == '0) begin
          res_d.status = hsmm_pkg::ST_EMPTY;
          state_d      = hsmm_pkg::S_OUT;
        end else begin
          state_d = hsmm_pkg::S_DGO;
        end
      end
      hsmm_pkg::S_DGO: begin
        div_req.start     = 1'b1;
        div_req.long_mode = (ph_q == 2'd0);
        state_d           = hsmm_pkg::S_DWAIT;
      end
      hsmm_pkg::S_DWAIT: begin
        if (div_done) begin
          case (ph_q)
            2'd0:    avg_d = div_q;
            2'd1:    res_d.average = div_f;
            2'd2:    res_d.minimum = div_f;
            default: res_d.maximum = div_f;
          endcase
          ph_d    = ph_q + 2'd1;
          state_d = (ph_q == 2'd3) ? hsmm_pkg::S_OUT : hsmm_pkg::S_DGO;
        end
      end
      hsmm_pkg::S_OUT: begin
        // hold until the output register is free
        if (!out_valid_q || m_axis_tready) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = hsmm_pkg::S_IDLE;
        end
      end
      default: state_d = hsmm_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= hsmm_pkg::S_INIT;
      out_valid_q <= 1'b0;
      dp_q        <= 2'd1;
      ph_q        <= 2'd0;
      b_q         <= '0;
      ini_q       <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      ph_q        <= ph_d;
      b_q         <= b_d;
      ini_q       <= ini_d;
      if (cfg_we_i) begin
        dp_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q  <= op_d;
    ch_q  <= ch_d;
    sel_q <= sel_d;
    val_q <= val_d;
    avg_q <= avg_d;
    res_q <= res_d;
    out_q <= out_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, out_q};

endmodule

/* test/histogram_min_max_avg_stats_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// histogram_min_max_avg_stats_tb
// Drives sample, bound, clear and read commands into the metering statistics
// block, keeps its own copy of the per-channel histograms and statistics, and
// checks every result transfer field by field against the predicted result.
// ----------------------------------------------------------------------------
module histogram_min_max_avg_stats_tb;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          s_axis_tvalid = 1'b0;
  logic                          s_axis_tready;
  logic [hsmm_pkg::IN_W-1:0]     s_axis_tdata = '0;
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;
  logic [hsmm_pkg::OUT_W-1:0]    m_axis_tdata;
  logic                          cfg_we_i = 1'b0;
  logic [1:0]                    cfg_wdata_i = 2'd0;

  histogram_min_max_avg_stats dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i)
  );

  // shadow of the block's state
  logic signed [31:0] bounds_q [hsmm_pkg::CHANNELS][hsmm_pkg::BINS];
  logic        [31:0] hist_q   [hsmm_pkg::CHANNELS][hsmm_pkg::BINS];
  longint             total_q  [hsmm_pkg::CHANNELS];
  logic signed [31:0] least_q  [hsmm_pkg::CHANNELS];
  logic signed [31:0] most_q   [hsmm_pkg::CHANNELS];
  logic        [31:0] count_q  [hsmm_pkg::CHANNELS];
  logic        [1:0]  places_q = 2'd1;

  logic [hsmm_pkg::IN_W-1:0] cmd_q [$];
  hsmm_pkg::res_t            due_q [$];
  int                        mismatches = 0;
  bit                        calm = 1'b0;

  initial forever #1 clk_i = ~clk_i;

  function automatic longint floor_by(longint a, longint b);
    longint q;
    q = a / b;
    if ((a % b) != 0 && a < 0) q--;
    return q;
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic logic [31:0] floor_places(longint v);
    longint stp;
    stp = 1;
    for (int k = places_q; k < 3; k++) stp *= 10;
    return 32'(clamp32(floor_by(v, stp) * stp));
  endfunction

  // work out the result of one accepted command and update the shadow
  function automatic void predict_result(logic [hsmm_pkg::IN_W-1:0] d);
    hsmm_pkg::op_e  op;
    int             ch, sel, b;
    longint         v, t;
    hsmm_pkg::res_t r;
    op  = hsmm_pkg::op_e'(d[1:0]);
    ch  = d[5:2];
    sel = d[9:6];
    v   = longint'($signed(d[41:10]));
    r   = '0;
    case (op)
      hsmm_pkg::OP_ACC: begin
        for (b = 0; b < hsmm_pkg::BINS; b++) if (v < longint'(bounds_q[ch][b])) break;
        if (b >= hsmm_pkg::BINS) begin
          r.status = hsmm_pkg::ST_REJECT;
          r.sample_count = count_q[ch];
        end else begin
          if (hist_q[ch][b] != '1) hist_q[ch][b]++;
          t = total_q[ch];
          if (v > 0 && t > 64'sh7fffffffffffffff - v) t = 64'sh7fffffffffffffff;
          else if (v < 0 && t < -64'sh7fffffffffffffff - 1 - v)
            t = -64'sh7fffffffffffffff - 1;
          else t += v;
          total_q[ch] = t;
          if (count_q[ch] == 0 || v < least_q[ch]) least_q[ch] = v[31:0];
          if (count_q[ch] == 0 || v > most_q[ch]) most_q[ch] = v[31:0];
          if (count_q[ch] != '1) count_q[ch]++;
          r.status = hsmm_pkg::ST_OK;
          r.bin_hit = b[hsmm_pkg::BIN_W-1:0];
          r.bin_count = hist_q[ch][b];
          r.sample_count = count_q[ch];
        end
      end
      hsmm_pkg::OP_BOUND: begin
        if (sel < hsmm_pkg::BINS) begin
          bounds_q[ch][sel] = v[31:0];
          r.bin_hit = sel[hsmm_pkg::BIN_W-1:0];
          r.bin_count = hist_q[ch][sel];
          r.sample_count = count_q[ch];
        end
      end
      hsmm_pkg::OP_CLEAR: begin
        for (int k = 0; k < hsmm_pkg::BINS; k++) hist_q[ch][k] = '0;
        total_q[ch] = 0;
        least_q[ch] = '0;
        most_q[ch] = '0;
        count_q[ch] = '0;
      end
      default: begin
        r.bin_hit = sel[hsmm_pkg::BIN_W-1:0];
        r.bin_count = (sel < hsmm_pkg::BINS) ? hist_q[ch][sel] : '0;
        r.sample_count = count_q[ch];
        if (count_q[ch] == 0) begin
          r.status = hsmm_pkg::ST_EMPTY;
        end else begin
          r.average = floor_places(clamp32(floor_by(total_q[ch], longint'(count_q[ch]))));
          r.minimum = floor_places(longint'(least_q[ch]));
          r.maximum = floor_places(longint'(most_q[ch]));
        end
      end
    endcase
    due_q.push_back(r);
  endfunction

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) predict_result(s_axis_tdata);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (cmd_q.size() > 0 && (calm || $urandom_range(99) >= 13)) begin
          s_axis_tdata  <= cmd_q.pop_front();
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    hsmm_pkg::res_t got, want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = hsmm_pkg::res_t'(m_axis_tdata[$bits(hsmm_pkg::res_t)-1:0]);
        if (due_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result transfer %h", got);
        end else begin
          want = due_q.pop_front();
          if (got.status !== want.status || got.bin_hit !== want.bin_hit ||
              got.bin_count !== want.bin_count || got.sample_count !== want.sample_count ||
              got.average !== want.average || got.minimum !== want.minimum ||
              got.maximum !== want.maximum) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("result mismatch: exp st=%0d bin=%0d bc=%0d sc=%0d avg=%0d min=%0d max=%0d",
                       want.status, want.bin_hit, want.bin_count, want.sample_count,
                       $signed(want.average), $signed(want.minimum), $signed(want.maximum));
              $display("                 got st=%0d bin=%0d bc=%0d sc=%0d avg=%0d min=%0d max=%0d",
                       got.status, got.bin_hit, got.bin_count, got.sample_count,
                       $signed(got.average), $signed(got.minimum), $signed(got.maximum));
            end
          end
        end
      end
      m_axis_tready <= calm || $urandom_range(99) >= 13;
    end
  end

  task automatic send(hsmm_pkg::op_e op, int ch, int sel, logic [31:0] v);
    cmd_q.push_back({6'b0, v, sel[3:0], ch[3:0], op});
  endtask

  // hold until every queued command is done and its result has arrived
  task automatic drain();
    do @(negedge clk_i);
    while (cmd_q.size() > 0 || s_axis_tvalid || due_q.size() > 0);
  endtask

  task automatic set_places(logic [1:0] dp);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= dp;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    places_q     = dp;
  endtask

  task automatic load_bounds(int ch);
    longint b;
    b = -longint'($urandom_range(3000000));
    for (int k = 0; k < hsmm_pkg::BINS; k++) begin
      b += $urandom_range(400000) + 1;
      if (k == hsmm_pkg::BINS - 1 && $urandom_range(2) == 0) b = 64'sd2147483647;
      send(hsmm_pkg::OP_BOUND, ch, k, b[31:0]);
    end
  endtask

  task automatic random_phase(int n);
    int     ch, pick;
    longint lo, hi, v;
    for (int i = 0; i < n; i++) begin
      ch = $urandom_range(hsmm_pkg::CHANNELS - 1);
      pick = $urandom_range(99);
      lo = bounds_q[ch][0];
      hi = bounds_q[ch][hsmm_pkg::BINS-1];
      if (lo > hi) begin v = lo; lo = hi; hi = v; end
      if (pick < 62) begin
        if ($urandom_range(9) < 8) v = lo - 500 + longint'($urandom) % (hi - lo + 1000);
        else v = longint'($signed($urandom));
        send(hsmm_pkg::OP_ACC, ch, $urandom_range(15), 32'(clamp32(v)));
      end else if (pick < 67) begin
        send(hsmm_pkg::OP_BOUND, ch, $urandom_range(15), $urandom);
      end else if (pick < 70) begin
        send(hsmm_pkg::OP_CLEAR, ch, $urandom_range(15), $urandom);
      end else begin
        send(hsmm_pkg::OP_READ, ch, $urandom_range(15), $urandom);
      end
      // keep the shadow bounds current for the sample ranges above
      if (cmd_q.size() > 8) while (cmd_q.size() > 4) @(posedge clk_i);
    end
  endtask

  initial begin
    for (int c = 0; c < hsmm_pkg::CHANNELS; c++) begin
      for (int k = 0; k < hsmm_pkg::BINS; k++) begin
        bounds_q[c][k] = '0;
        hist_q[c][k]   = '0;
      end
      total_q[c] = 0;
      least_q[c] = '0;
      most_q[c]  = '0;
      count_q[c] = '0;
    end
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // state straight after reset: zero bounds, empty channels
    calm = 1'b1;
    send(hsmm_pkg::OP_READ, 2, 1, '0);
    send(hsmm_pkg::OP_ACC, 2, 0, 32'hfffffff0);
    send(hsmm_pkg::OP_ACC, 2, 0, 32'h00000005);
    send(hsmm_pkg::OP_READ, 2, 0, '0);

    // clear and load every channel
    for (int c = 0; c < hsmm_pkg::CHANNELS; c++) begin
      send(hsmm_pkg::OP_CLEAR, c, 0, '0);
      load_bounds(c);
    end
    drain();
    calm = 1'b0;

    // directed: full-range channel, extremes, empty read, out-of-range bins
    for (int k = 0; k < hsmm_pkg::BINS; k++)
      send(hsmm_pkg::OP_BOUND, 15, k,
           (k == hsmm_pkg::BINS - 1) ? 32'h7fffffff : 32'h80000001 + k * 32'h15000000);
    send(hsmm_pkg::OP_READ, 15, 3, '0);
    send(hsmm_pkg::OP_ACC, 15, 0, 32'h80000000);
    send(hsmm_pkg::OP_ACC, 15, 0, 32'h7ffffffe);
    send(hsmm_pkg::OP_ACC, 15, 0, 32'h7fffffff);
    send(hsmm_pkg::OP_ACC, 15, 0, 32'hffffff9d);
    send(hsmm_pkg::OP_BOUND, 15, 12, 32'h12345678);
    send(hsmm_pkg::OP_BOUND, 15, 15, 32'hffffffff);
    send(hsmm_pkg::OP_READ, 15, 0, '0);
    send(hsmm_pkg::OP_READ, 15, 13, '0);
    drain();
    set_places(2'd3);
    send(hsmm_pkg::OP_READ, 15, 11, '0);
    drain();
    set_places(2'd0);
    send(hsmm_pkg::OP_READ, 15, 11, '0);
    send(hsmm_pkg::OP_CLEAR, 15, 0, '0);
    send(hsmm_pkg::OP_READ, 15, 0, '0);

    random_phase(280);
    set_places(2'd2);
    calm = 1'b1;
    random_phase(280);
    calm = 1'b0;
    set_places(2'd3);
    random_phase(280);
    set_places(2'd1);
    random_phase(280);

    drain();
    repeat (400) @(posedge clk_i);
    if (mismatches == 0 && due_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #8000000;
    $display("Mismatches found");
    $finish;
  end

endmodule
